FILE: rtl/nrgp_pkg.sv
// Package for the GPRMC sentence parser: command types, field widths,
// header table and the saturating decimal accumulate step.
// No dependencies.
package nrgp_pkg;

    localparam int MAX_SENTENCE_CHARS_DEF = 99;
    localparam int MAX_FIELD_CHARS_DEF    = 14;
    localparam int QUEUE_DEPTH_DEF        = 4;

    localparam int POS_W    = 7;
    localparam int FCNT_W   = 4;
    localparam int FIELD_W  = 3;
    localparam int VALUE_W  = 31;
    localparam int HEADER_LEN = 6;

    localparam logic [FIELD_W-1:0] LAT_FIELD = 3'd3;
    localparam logic [FIELD_W-1:0] LON_FIELD = 3'd5;
    localparam logic [FIELD_W-1:0] LAST_FIELD = 3'd6;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [1:0] REG_LAT_UPPER = 2'd0;
    localparam logic [1:0] REG_LAT_LOWER = 2'd1;
    localparam logic [1:0] REG_LON_UPPER = 2'd2;
    localparam logic [1:0] REG_LON_LOWER = 2'd3;

    localparam logic [VALUE_W-1:0] LAT_UPPER_RST = 31'd30142500;
    localparam logic [VALUE_W-1:0] LAT_LOWER_RST = 31'd30141500;
    localparam logic [VALUE_W-1:0] LON_UPPER_RST = 31'd97493500;
    localparam logic [VALUE_W-1:0] LON_LOWER_RST = 31'd97492000;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_LAT,
        CMD_LON,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       match;
        logic       is_digit;
        logic [3:0] digit;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lat_upper;
        logic [VALUE_W-1:0] lat_lower;
        logic [VALUE_W-1:0] lon_upper;
        logic [VALUE_W-1:0] lon_lower;
    } bounds_t;

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CHAR_DOLLAR;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4D;
            3'd5:    ch = 8'h43;
            default: ch = CHAR_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [VALUE_W-1:0] acc_step(input logic [VALUE_W-1:0] acc,
                                                    input logic [3:0] d);
        logic [VALUE_W+3:0] v;
        v = ((VALUE_W+4)'(acc) << 3) + ((VALUE_W+4)'(acc) << 1) + (VALUE_W+4)'(d);
        if (v > (VALUE_W+4)'(VALUE_MAX)) begin
            return VALUE_MAX;
        end
        return v[VALUE_W-1:0];
    endfunction

endpackage

FILE: rtl/nrgp_front.sv
// Front end: takes bytes, tracks sentence framing, header match and field
// number, and issues commands to the queue. Depends on nrgp_pkg.
module nrgp_front #(
    parameter int MAX_SENTENCE_CHARS = nrgp_pkg::MAX_SENTENCE_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,     // rx_byte
    input  logic          q_full,
    output logic          q_push,
    output nrgp_pkg::cmd_t q_cmd
);
    import nrgp_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SENTENCE_CHARS);

    logic               capturing_reg, capturing_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               hdr_ok_reg, hdr_ok_next;
    logic [FIELD_W-1:0] field_reg, field_next;

    logic accept;
    logic is_eol;
    logic is_digit;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_eol   = s_tdata inside {CHAR_CR, CHAR_LF};
    assign is_digit = s_tdata inside {[8'h30:8'h39]};

    always_comb begin
        capturing_next = capturing_reg;
        pos_next       = pos_reg;
        hdr_ok_next    = hdr_ok_reg;
        field_next     = field_reg;
        q_push         = 1'b0;
        q_cmd.kind     = CMD_START;
        q_cmd.match    = 1'b0;
        q_cmd.is_digit = is_digit;
        q_cmd.digit    = s_tdata[3:0];
        if (accept) begin
            if (!capturing_reg) begin
                if (s_tdata == CHAR_DOLLAR) begin
                    capturing_next = 1'b1;
                    pos_next       = POS_W'(1);
                    hdr_ok_next    = 1'b1;
                    field_next     = '0;
                    q_push         = 1'b1;
                end
            end else if (is_eol) begin
                capturing_next = 1'b0;
                q_push         = 1'b1;
                q_cmd.kind     = CMD_END;
                q_cmd.match    = hdr_ok_reg && (pos_reg >= POS_W'(HEADER_LEN));
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg < POS_W'(HEADER_LEN) && s_tdata != header_char(pos_reg[2:0])) begin
                    hdr_ok_next = 1'b0;
                end
                if (s_tdata == CHAR_NUL) begin
                    pos_next = POS_MAX;
                end else if (s_tdata == CHAR_COMMA) begin
                    if (field_reg < LAST_FIELD) begin
                        field_next = field_reg + FIELD_W'(1);
                    end
                end else if (field_reg == LAT_FIELD) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_LAT;
                end else if (field_reg == LON_FIELD) begin
                    q_push     = 1'b1;
                    q_cmd.kind = CMD_LON;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg <= 1'b0;
            pos_reg       <= '0;
            hdr_ok_reg    <= 1'b0;
            field_reg     <= '0;
        end else begin
            capturing_reg <= capturing_next;
            pos_reg       <= pos_next;
            hdr_ok_reg    <= hdr_ok_next;
            field_reg     <= field_next;
        end
    end

    a_field_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        field_reg <= LAST_FIELD)
        else $error("field number past six");
    a_pos_open: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> (pos_reg != '0 && pos_reg <= POS_MAX))
        else $error("position out of range while capturing");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into full queue");

endmodule

FILE: rtl/nrgp_queue.sv
// Short command queue between front and back ends.
// Depends on nrgp_pkg.
module nrgp_queue #(
    parameter int DEPTH = nrgp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  nrgp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output nrgp_pkg::cmd_t head_cmd
);
    import nrgp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");

endmodule

FILE: rtl/nrgp_back.sv
// Back end: applies queued commands to the coordinate accumulators and
// drives the result register with the geofence flag. Depends on nrgp_pkg.
module nrgp_back #(
    parameter int MAX_FIELD_CHARS = nrgp_pkg::MAX_FIELD_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  nrgp_pkg::cmd_t    q_head,
    output logic              q_pop,
    input  nrgp_pkg::bounds_t bounds,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata    // lat_value, lon_value, outside, zero pad
);
    import nrgp_pkg::*;

    localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FIELD_CHARS);

    logic [VALUE_W-1:0] lat_acc_reg, lat_acc_next;
    logic [VALUE_W-1:0] lon_acc_reg, lon_acc_next;
    logic [FCNT_W-1:0]  lat_cnt_reg, lat_cnt_next;
    logic [FCNT_W-1:0]  lon_cnt_reg, lon_cnt_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_lat_reg, out_lon_reg;
    logic               out_flag_reg;

    logic out_free;
    logic emit;
    logic outside;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_not_empty && (q_head.kind != CMD_END || out_free);
    assign emit     = q_pop && q_head.kind == CMD_END && q_head.match;
    assign outside  = (lat_acc_reg > bounds.lat_upper) || (lat_acc_reg < bounds.lat_lower)
                   || (lon_acc_reg > bounds.lon_upper) || (lon_acc_reg < bounds.lon_lower);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_flag_reg, out_lon_reg, out_lat_reg};

    always_comb begin
        lat_acc_next = lat_acc_reg;
        lon_acc_next = lon_acc_reg;
        lat_cnt_next = lat_cnt_reg;
        lon_cnt_next = lon_cnt_reg;
        if (q_pop) begin
            case (q_head.kind)
                CMD_START: begin
                    lat_acc_next = '0;
                    lon_acc_next = '0;
                    lat_cnt_next = '0;
                    lon_cnt_next = '0;
                end
                CMD_LAT: begin
                    if (lat_cnt_reg < FCNT_MAX) begin
                        lat_cnt_next = lat_cnt_reg + FCNT_W'(1);
                        if (q_head.is_digit) begin
                            lat_acc_next = acc_step(lat_acc_reg, q_head.digit);
                        end
                    end
                end
                CMD_LON: begin
                    if (lon_cnt_reg < FCNT_MAX) begin
                        lon_cnt_next = lon_cnt_reg + FCNT_W'(1);
                        if (q_head.is_digit) begin
                            lon_acc_next = acc_step(lon_acc_reg, q_head.digit);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_acc_reg   <= '0;
            lon_acc_reg   <= '0;
            lat_cnt_reg   <= '0;
            lon_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            lat_acc_reg <= lat_acc_next;
            lon_acc_reg <= lon_acc_next;
            lat_cnt_reg <= lat_cnt_next;
            lon_cnt_reg <= lon_cnt_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_lat_reg  <= lat_acc_reg;
            out_lon_reg  <= lon_acc_reg;
            out_flag_reg <= outside;
        end
    end

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> out_valid_reg)
        else $error("result lost after sentence end");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !emit)
        else $error("pending result overwritten");
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (lat_cnt_reg <= FCNT_MAX) && (lon_cnt_reg <= FCNT_MAX))
        else $error("field character count past cap");

endmodule

FILE: rtl/nmea_rmc_geofence_parser_core.sv
// Top level of the GPRMC sentence parser with geofence check: config
// registers, front end, command queue and back end. Depends on nrgp_pkg.
//
//   channel   ports            payload
//   input     s_tvalid/tready  s_tdata[7:0] = rx_byte
//   result    m_tvalid/tready  m_tdata[30:0] lat_value, [61:31] lon_value, [62] outside
//   config    cfg_wr_en        cfg_addr selects bound, cfg_wdata[30:0]
//
// One byte per cycle while the queue is not full; a result for a CR/LF byte
// passes through a queue slot, then the result register, before m_tvalid.
// The queue holds QUEUE_DEPTH commands; input stalls only when it is full.
// A result waiting on m_tready stalls the back end at the next sentence end.
// Reset is synchronous on aresetn and restores the default bounds.
module nmea_rmc_geofence_parser_core #(
    parameter int MAX_SENTENCE_CHARS = nrgp_pkg::MAX_SENTENCE_CHARS_DEF,
    parameter int MAX_FIELD_CHARS    = nrgp_pkg::MAX_FIELD_CHARS_DEF,
    parameter int QUEUE_DEPTH        = nrgp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // lat_value, lon_value, outside, zero pad
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata
);
    import nrgp_pkg::*;

    bounds_t bounds_reg;
    cmd_t    push_cmd;
    cmd_t    head_cmd;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.lat_upper <= LAT_UPPER_RST;
            bounds_reg.lat_lower <= LAT_LOWER_RST;
            bounds_reg.lon_upper <= LON_UPPER_RST;
            bounds_reg.lon_lower <= LON_LOWER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LAT_UPPER: bounds_reg.lat_upper <= cfg_wdata;
                REG_LAT_LOWER: bounds_reg.lat_lower <= cfg_wdata;
                REG_LON_UPPER: bounds_reg.lon_upper <= cfg_wdata;
                REG_LON_LOWER: bounds_reg.lon_lower <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    nrgp_front #(
        .MAX_SENTENCE_CHARS(MAX_SENTENCE_CHARS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    nrgp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    nrgp_back #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .bounds      (bounds_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
